[sv/mt_pkg.sv]
// Shared types, widths and codes for the Mealy transducer.
package mt_pkg;

  localparam int MAX_TRANSITIONS = 32;
  localparam int MAX_STATES      = 16;
  localparam int IDX_W           = $clog2(MAX_TRANSITIONS);
  localparam int CNT_W           = 6;
  localparam int STATE_W         = 4;
  localparam int SYM_W           = 8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_END    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_EMIT    = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_SKIP    = 3'd2,
    ST_ACCEPT  = 3'd3,
    ST_REJECT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_TRANSITION_COUNT = 2'd0,
    REG_INITIAL_STATE    = 2'd1,
    REG_FINAL_STATE_MASK = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   in_symbol;
    logic [SYM_W-1:0]   out_symbol;
    logic [STATE_W-1:0] to_state;
  } trans_t;

endpackage

[sv/mt_table.sv]
// Transition table memory with registered read and the shared match comparator.
module mt_table
  import mt_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  trans_t             wr_entry,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [STATE_W-1:0] key_state,
  input  logic [SYM_W-1:0]   key_symbol,
  output trans_t             rd_entry,
  output logic               hit
);

  trans_t mem [MAX_TRANSITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

  // The entry read last cycle is compared against the current key.
  assign hit = (rd_entry.from_state == key_state) && (rd_entry.in_symbol == key_symbol);

endmodule

[sv/mealy_transducer.sv]
// Programmable Mealy transducer: APB registers, transition table and scan sequencer.
//
// Input items arrive on the s_ channel: tuser carries the operation (load table
// entry, process symbol, end of word) and tdata the entry fields and symbol.
// A load item writes one table entry and gives no result. A symbol item scans
// the table one entry per cycle from entry zero for the first entry matching
// the current state and symbol, through a single comparator behind the table's
// registered read port. An end item reports accepted or rejected at once.
// Each symbol or end item gives one result on the m_ channel (status in tuser,
// output symbol and state in tdata).
// A symbol item runs the scan in S_SCAN until the first match or until all n entries in
// use (transition_count, capped at 32) have been examined, then moves to S_DONE; an end
// item, a skipped symbol or a symbol with no entries in use goes straight to S_DONE.
// s_tready is high only while the sequencer is idle, so no new item is taken before the
// last one is through, while a load leaves the sequencer idle and so does not hold it.
// A finished result waits in the sequencer until the output register is free;
// a stalled receiver therefore holds back input once a second result is ready.
// Reset clears the registers, the current state and the word flags; the table
// holds no defined contents until entries are loaded.
module mealy_transducer
  import mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[4:0], entry_from_state[8:5], entry_in_symbol[16:9],
  // entry_out_symbol[24:17], entry_to_state[28:25], symbol[36:29], zero pad
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_symbol[7:0], state_now[11:8], zero pad
  output logic [15:0] m_tdata,
  // status[2:0]
  output logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [CNT_W-1:0]   transition_count;
  logic [STATE_W-1:0] initial_state;
  logic [15:0]        final_state_mask;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_count <= '0;
      initial_state    <= '0;
      final_state_mask <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TRANSITION_COUNT: transition_count <= pwdata[CNT_W-1:0];
        REG_INITIAL_STATE:    initial_state    <= pwdata[STATE_W-1:0];
        REG_FINAL_STATE_MASK: final_state_mask <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_TRANSITION_COUNT: prdata = {{(32-CNT_W){1'b0}}, transition_count};
      REG_INITIAL_STATE:    prdata = {{(32-STATE_W){1'b0}}, initial_state};
      REG_FINAL_STATE_MASK: prdata = {16'd0, final_state_mask};
      default:              prdata = '0;
    endcase
  end

  // Input field unpacking
  logic [IDX_W-1:0] in_index;
  trans_t           in_entry;
  logic [SYM_W-1:0] in_symbol;

  assign in_index            = s_tdata[4:0];
  assign in_entry.from_state = s_tdata[8:5];
  assign in_entry.in_symbol  = s_tdata[16:9];
  assign in_entry.out_symbol = s_tdata[24:17];
  assign in_entry.to_state   = s_tdata[28:25];
  assign in_symbol           = s_tdata[36:29];

  // Sequencer registers
  seq_state_t         state, state_next;
  logic [STATE_W-1:0] cur_state, cur_state_next;
  logic               word_active, word_active_next;
  logic               word_failed, word_failed_next;
  logic [SYM_W-1:0]   sym, sym_next;
  logic [CNT_W-1:0]   rd_ptr, rd_ptr_next;
  logic               chk_valid, chk_valid_next;
  logic [CNT_W-1:0]   scan_n, scan_n_next;
  status_t            res_status, res_status_next;
  logic [SYM_W-1:0]   res_symbol, res_symbol_next;
  logic [STATE_W-1:0] res_state, res_state_next;
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  logic [SYM_W-1:0]   out_symbol, out_symbol_next;
  logic [STATE_W-1:0] out_state, out_state_next;

  // Table interface
  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  trans_t           rd_entry;
  logic             hit;

  mt_table u_table (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (in_index),
    .wr_entry   (in_entry),
    .rd_addr    (rd_addr),
    .key_state  (cur_state),
    .key_symbol (sym),
    .rd_entry   (rd_entry),
    .hit        (hit)
  );

  logic [STATE_W-1:0] word_state;
  logic [CNT_W-1:0]   count_lim;

  // State the word is in: a word not yet started stands at the initial state.
  assign word_state = word_active ? cur_state : initial_state;
  assign count_lim  = (transition_count > CNT_W'(MAX_TRANSITIONS)) ?
                      CNT_W'(MAX_TRANSITIONS) : transition_count;
  assign s_tready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cur_state_next   = cur_state;
    word_active_next = word_active;
    word_failed_next = word_failed;
    sym_next         = sym;
    rd_ptr_next      = rd_ptr;
    chk_valid_next   = chk_valid;
    scan_n_next      = scan_n;
    res_status_next  = res_status;
    res_symbol_next  = res_symbol;
    res_state_next   = res_state;
    out_valid_next   = out_valid && !m_tready;
    out_status_next  = out_status;
    out_symbol_next  = out_symbol;
    out_state_next   = out_state;
    wr_en            = 1'b0;
    rd_addr          = rd_ptr[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (op_t'(s_tuser))
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_SYMBOL: begin
              sym_next = in_symbol;
              if (word_failed) begin
                res_status_next = ST_SKIP;
                res_symbol_next = '0;
                res_state_next  = cur_state;
                state_next      = S_DONE;
              end else begin
                cur_state_next   = word_state;
                word_active_next = 1'b1;
                if (count_lim == '0) begin
                  res_status_next  = ST_NOMATCH;
                  res_symbol_next  = '0;
                  res_state_next   = word_state;
                  word_failed_next = 1'b1;
                  state_next       = S_DONE;
                end else begin
                  // Entry zero is read now and compared in the first scan cycle.
                  rd_addr        = '0;
                  rd_ptr_next    = CNT_W'(1);
                  chk_valid_next = 1'b1;
                  scan_n_next    = count_lim;
                  state_next     = S_SCAN;
                end
              end
            end
            OP_END: begin
              res_status_next  = (!word_failed && final_state_mask[word_state]) ?
                                 ST_ACCEPT : ST_REJECT;
              res_symbol_next  = '0;
              res_state_next   = initial_state;
              cur_state_next   = initial_state;
              word_active_next = 1'b0;
              word_failed_next = 1'b0;
              state_next       = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rd_ptr_next    = rd_ptr + CNT_W'(1);
        chk_valid_next = (rd_ptr < scan_n);
        if (chk_valid && hit) begin
          res_status_next = ST_EMIT;
          res_symbol_next = rd_entry.out_symbol;
          res_state_next  = rd_entry.to_state;
          cur_state_next  = rd_entry.to_state;
          state_next      = S_DONE;
        end else if (!chk_valid) begin
          res_status_next  = ST_NOMATCH;
          res_symbol_next  = '0;
          res_state_next   = cur_state;
          word_failed_next = 1'b1;
          state_next       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_symbol_next = res_symbol;
          out_state_next  = res_state;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state   <= '0;
      word_active <= 1'b0;
      word_failed <= 1'b0;
      out_valid   <= 1'b0;
      rd_ptr      <= '0;
      chk_valid   <= 1'b0;
      scan_n      <= '0;
    end else begin
      cur_state   <= cur_state_next;
      word_active <= word_active_next;
      word_failed <= word_failed_next;
      out_valid   <= out_valid_next;
      rd_ptr      <= rd_ptr_next;
      chk_valid   <= chk_valid_next;
      scan_n      <= scan_n_next;
    end
  end

  always_ff @(posedge clk) begin
    sym        <= sym_next;
    res_status <= res_status_next;
    res_symbol <= res_symbol_next;
    res_state  <= res_state_next;
    out_status <= out_status_next;
    out_symbol <= out_symbol_next;
    out_state  <= out_state_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {4'd0, out_state, out_symbol};

  // A word can only have failed once it has started.
  a_failed_active: assert property (@(posedge clk) disable iff (rst)
    word_failed |-> word_active)
    else $error("word marked failed outside an active word");

  // The scan never runs past the capped entry count.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (scan_n != '0) && (scan_n <= CNT_W'(MAX_TRANSITIONS)) &&
                        (rd_ptr <= scan_n + CNT_W'(1)))
    else $error("table scan out of range");

  // Only an emitted symbol carries a non-zero output symbol.
  a_zero_symbol: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_EMIT) |-> (m_tdata[7:0] == '0))
    else $error("output symbol set without an emit status");

  // An end item closes the word and returns to the initial state.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_END) |=>
      !word_active && !word_failed && (cur_state == $past(initial_state)))
    else $error("end item did not close the word");

  // A load item gives no result: the sequencer stays idle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> state == S_IDLE)
    else $error("load item left the idle state");

endmodule

[verif/mt_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the Mealy transducer: predicts each result from accepted items and checks them.
module mt_checker
  import mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // entry_index[4:0], entry_from_state[8:5], entry_in_symbol[16:9],
  // entry_out_symbol[24:17], entry_to_state[28:25], symbol[36:29], zero pad
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // out_symbol[7:0], state_now[11:8], zero pad
  input  logic [15:0] m_tdata,
  // status[2:0]
  input  logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          results_due
);

  typedef struct packed {
    logic [2:0]         status;
    logic [SYM_W-1:0]   out_symbol;
    logic [STATE_W-1:0] state_now;
  } outcome_t;

  trans_t             rules [MAX_TRANSITIONS];
  logic [STATE_W-1:0] cur_state;
  logic               in_word;
  logic               word_dead;
  logic [CNT_W-1:0]   rule_count;
  logic [STATE_W-1:0] start_state;
  logic [15:0]        accept_mask;
  outcome_t           due_q [$];
  int                 errors = 0;

  // Advances the predicted machine by one item; returns 1 when the item gives a result.
  function automatic bit step_machine(input logic [1:0] op, input logic [39:0] d,
                                      output outcome_t res);
    int                 limit;
    bit                 hit;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] last;
    res  = '{status: ST_EMIT, out_symbol: '0, state_now: '0};
    hit  = 1'b0;
    sym  = d[36:29];
    case (op)
      OP_LOAD: begin
        rules[d[4:0]] = '{from_state: d[8:5], in_symbol: d[16:9],
                          out_symbol: d[24:17], to_state: d[28:25]};
        return 1'b0;
      end
      OP_SYMBOL: begin
        if (!in_word) begin
          cur_state = start_state;
          in_word   = 1'b1;
        end
        if (word_dead) begin
          res.status = ST_SKIP;
        end else begin
          limit = (rule_count > MAX_TRANSITIONS) ? MAX_TRANSITIONS : rule_count;
          for (int i = 0; i < limit && !hit; i++) begin
            if (rules[i].from_state == cur_state && rules[i].in_symbol == sym) begin
              hit            = 1'b1;
              res.out_symbol = rules[i].out_symbol;
              cur_state      = rules[i].to_state;
            end
          end
          if (hit) begin
            res.status = ST_EMIT;
          end else begin
            res.status = ST_NOMATCH;
            word_dead  = 1'b1;
          end
        end
      end
      OP_END: begin
        // An empty word is judged on the state it would have started in.
        last = in_word ? cur_state : start_state;
        res.status = (!word_dead && accept_mask[last]) ? ST_ACCEPT : ST_REJECT;
        cur_state = start_state;
        in_word   = 1'b0;
        word_dead = 1'b0;
      end
      default: return 1'b0;
    endcase
    res.state_now = cur_state;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      cur_state   = '0;
      in_word     = 1'b0;
      word_dead   = 1'b0;
      rule_count  = '0;
      start_state = '0;
      accept_mask = '0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TRANSITION_COUNT: rule_count  = pwdata[CNT_W-1:0];
          REG_INITIAL_STATE:    start_state = pwdata[STATE_W-1:0];
          REG_FINAL_STATE_MASK: accept_mask = pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen = '{status: m_tuser, out_symbol: m_tdata[7:0], state_now: m_tdata[11:8]};
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with none expected: status %0d symbol %02h state %0d",
                     $time, seen.status, seen.out_symbol, seen.state_now);
        end else begin
          want = due_q.pop_front();
          if (seen.status !== want.status || seen.out_symbol !== want.out_symbol ||
              seen.state_now !== want.state_now) begin
            errors++;
            if (errors <= 10)
              $display("%0t: wrong result: expected status %0d symbol %02h state %0d, %s",
                       $time, want.status, want.out_symbol, want.state_now,
                       $sformatf("got status %0d symbol %02h state %0d",
                                 seen.status, seen.out_symbol, seen.state_now));
          end
        end
      end
      if (s_tvalid && s_tready && step_machine(s_tuser, s_tdata, want))
        due_q.push_back(want);
    end
    fail_count  <= errors;
    results_due <= due_q.size();
  end

endmodule

[verif/tb_mealy_transducer.sv]
`timescale 1ns / 1ps
// Top-level testbench for the Mealy transducer: clock, reset, stimulus and verdict.
module tb_mealy_transducer;
  import mt_pkg::*;

  localparam int TIMEOUT_CYCLES = 800000;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int DRAIN_CYCLES   = 48;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          results_due;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  int          random_sent;

  // Entry i of a well-formed table maps (state_pool[i/8], alphabet[i%8]).
  logic [STATE_W-1:0] state_pool [4];
  logic [SYM_W-1:0]   alphabet [8];

  mealy_transducer i_dut (.*);

  mt_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a fresh random stall before every item, none in quiet phases.
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  function automatic logic [39:0] symbol_word(input logic [SYM_W-1:0] sym);
    logic [28:0] filler;
    filler = 29'($urandom);
    return {3'b000, sym, filler};
  endfunction

  function automatic logic [39:0] pack_rule(input logic [4:0] idx,
                                            input logic [STATE_W-1:0] from_s,
                                            input logic [SYM_W-1:0] in_s,
                                            input logic [SYM_W-1:0] out_s,
                                            input logic [STATE_W-1:0] to_s);
    logic [SYM_W-1:0] filler;
    filler = SYM_W'($urandom);
    return {3'b000, filler, to_s, out_s, in_s, from_s, idx};
  endfunction

  function automatic logic [39:0] lawful_rule(input int i);
    return pack_rule(i[4:0], state_pool[(i / 8) % 4], alphabet[i % 8],
                     SYM_W'($urandom_range(0, 255)), state_pool[$urandom_range(0, 3)]);
  endfunction

  task automatic send(input logic [1:0] op, input logic [39:0] payload);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= payload;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
  endtask

  // Holds the sender back until every result is in and a trailing load has had time to finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t which, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_checks();
    // Nothing is in use yet, so the first symbol misses and the rest of the word is skipped.
    send(OP_SYMBOL, symbol_word(8'h00));
    send(OP_SYMBOL, symbol_word(8'hFF));
    send(OP_END, symbol_word(8'h00));
    send(OP_END, symbol_word(8'hFF));
    send(OP_SPARE, symbol_word(8'hA5));

    state_pool = '{4'hF, 4'h0, 4'h5, 4'hA};
    alphabet   = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7E, 8'h3C};
    for (int i = 0; i < MAX_TRANSITIONS; i++) send(OP_LOAD, lawful_rule(i));
    settle();
    reg_write(REG_TRANSITION_COUNT, 32);
    reg_write(REG_INITIAL_STATE, 15);
    reg_write(REG_FINAL_STATE_MASK, 32'h0000_8421);

    send(OP_END, symbol_word(8'h11));
    for (int k = 0; k < 8; k++) send(OP_SYMBOL, symbol_word(alphabet[k]));
    send(OP_END, symbol_word(8'h22));
    send(OP_SYMBOL, symbol_word(alphabet[3]));
    send(OP_SYMBOL, symbol_word(8'h42));
    send(OP_SYMBOL, symbol_word(alphabet[0]));
    send(OP_SPARE, symbol_word(8'h00));
    send(OP_END, symbol_word(8'h33));

    // The word stays open while the start state changes; it only applies to the next word.
    send(OP_SYMBOL, symbol_word(alphabet[1]));
    settle();
    reg_write(REG_INITIAL_STATE, 0);
    reg_write(REG_FINAL_STATE_MASK, 32'h0000_FFFF);
    send(OP_SYMBOL, symbol_word(alphabet[2]));
    send(OP_END, symbol_word(8'h44));

    settle();
    reg_write(REG_TRANSITION_COUNT, 63);
    send(OP_SYMBOL, symbol_word(alphabet[7]));
    send(OP_SYMBOL, symbol_word(alphabet[6]));
    send(OP_END, symbol_word(8'h55));

    settle();
    reg_write(REG_TRANSITION_COUNT, 1);
    reg_write(REG_FINAL_STATE_MASK, 32'h0000_0000);
    send(OP_SYMBOL, symbol_word(alphabet[0]));
    send(OP_END, symbol_word(8'h66));
  endtask

  task automatic random_phases();
    int          pick;
    bit          rebuild;
    logic [31:0] value;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      quiet   = ($urandom_range(0, 4) == 0);
      rebuild = ($urandom_range(0, 2) == 0);
      if (rebuild) begin
        for (int k = 0; k < 4; k++) state_pool[k] = STATE_W'($urandom_range(0, 15));
        for (int k = 0; k < 8; k++) alphabet[k] = SYM_W'($urandom_range(0, 255));
      end

      pick = $urandom_range(0, 9);
      if (pick == 0)      value = 0;
      else if (pick == 1) value = 1;
      else if (pick == 2) value = $urandom_range(33, 63);
      else if (pick < 6)  value = 32;
      else                value = $urandom_range(2, 32);
      reg_write(REG_TRANSITION_COUNT, value);
      if ($urandom_range(0, 3) == 0) value = $urandom_range(0, 15);
      else                           value = 32'(state_pool[$urandom_range(0, 3)]);
      reg_write(REG_INITIAL_STATE, value);
      pick = $urandom_range(0, 5);
      if (pick == 0)      value = 32'h0000_0000;
      else if (pick == 1) value = 32'h0000_FFFF;
      else                value = $urandom_range(0, 16'hFFFF);
      reg_write(REG_FINAL_STATE_MASK, value);

      if (rebuild) begin
        for (int i = 0; i < MAX_TRANSITIONS; i++) send(OP_LOAD, lawful_rule(i));
        random_sent += MAX_TRANSITIONS;
      end

      // Mostly words over the table's alphabet, with stray symbols, reloads and spare ops mixed in.
      for (int n = $urandom_range(40, 160); n > 0; n--) begin
        pick = $urandom_range(0, 99);
        if (pick < 58)
          send(OP_SYMBOL, symbol_word(alphabet[$urandom_range(0, 7)]));
        else if (pick < 66)
          send(OP_SYMBOL, symbol_word(SYM_W'($urandom_range(0, 255))));
        else if (pick < 84)
          send(OP_END, symbol_word(SYM_W'($urandom_range(0, 255))));
        else if (pick < 94)
          send(OP_LOAD, lawful_rule($urandom_range(0, 31)));
        else if (pick < 97)
          send(OP_LOAD, pack_rule(5'($urandom_range(0, 31)),
                                  STATE_W'($urandom_range(0, 15)),
                                  SYM_W'($urandom_range(0, 255)),
                                  SYM_W'($urandom_range(0, 255)),
                                  STATE_W'($urandom_range(0, 15))));
        else
          send(OP_SPARE, symbol_word(SYM_W'($urandom_range(0, 255))));
        if (pick < 97) random_sent++;
      end
    end
  endtask

  initial begin
    rst     <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    directed_checks();
    random_phases();
    settle();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
